[rtl/core/blaf_pkg.sv]
package blaf_pkg;

  localparam int DEPTH_DEFAULT = 512;

  localparam int BYTE_W  = 20;
  localparam int TIME_W  = 32;
  localparam int HND_W   = 16;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 10;
  localparam int STAT_W  = 3;
  localparam int DROP_W  = 32;
  localparam int CFG_W   = 32;

  localparam logic [BYTE_W-1:0] MAX_BYTES_RESET = 20'd100000;
  localparam logic [TIME_W-1:0] MAX_DELAY_RESET = 32'd10000000;

  localparam logic REG_MAX_BYTES = 1'b0;
  localparam logic REG_MAX_DELAY = 1'b1;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_FLUSH   = 2'd3;

  localparam logic [STAT_W-1:0] ST_ACCEPTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROP_BYTES = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROP_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DEQUEUED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd4;
  localparam logic [STAT_W-1:0] ST_QUERIED    = 3'd5;
  localparam logic [STAT_W-1:0] ST_FLUSHED    = 3'd6;

  typedef struct packed {
    logic [HND_W-1:0]  handle;
    logic [LEN_W-1:0]  length;
    logic [TIME_W-1:0] stamp;
  } desc_t;

endpackage

[rtl/core/blaf_desc_ram.sv]
module blaf_desc_ram #(
  parameter int DEPTH = blaf_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  blaf_pkg::desc_t          wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output blaf_pkg::desc_t          rd_data
);

  blaf_pkg::desc_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/byte_limited_aging_fifo.sv]
// Byte-limited aging FIFO of packet descriptors.
// A request is taken at a rising edge with start high and busy low; it carries
// operation (enqueue, dequeue, query, flush), current_time, and for enqueue the
// packet_handle and packet_length. Each request yields exactly one result,
// shown for one cycle with done high: status, the dequeued handle and length,
// the number of entries aged out, occupancy, bytes held, bytes free and the
// running drop count. The receiver cannot stall; results are simply presented.
// A flush reports in the cycle after acceptance. Any other request first
// ages out E entries at the head of the queue, the head-of-queue check looping
// one entry per cycle through the descriptor memory read port (registered
// read), and then reports. Except for a flush, busy is high from acceptance
// until the result is presented, and a new request may be taken in the cycle
// done is high.
// max_bytes and max_delay are written through cfg_write/cfg_index/cfg_data; the user
// must write them while no request is in progress, which the block does not enforce.
// Reset (synchronous, active high) empties the queue, clears the drop count
// and restores both limits to their defaults; memory contents are not cleared.
module byte_limited_aging_fifo #(
  parameter int DEPTH = blaf_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [blaf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation,
  input  logic [blaf_pkg::TIME_W-1:0]    current_time,
  input  logic [blaf_pkg::HND_W-1:0]     packet_handle,
  input  logic [blaf_pkg::LEN_W-1:0]     packet_length,
  output logic                           done,
  output logic [blaf_pkg::STAT_W-1:0]    status,
  output logic [blaf_pkg::HND_W-1:0]     out_handle,
  output logic [blaf_pkg::LEN_W-1:0]     out_length,
  output logic [blaf_pkg::CNT_W-1:0]     expired_count,
  output logic [blaf_pkg::CNT_W-1:0]     packet_count,
  output logic [blaf_pkg::BYTE_W-1:0]    bytes_held,
  output logic [blaf_pkg::BYTE_W-1:0]    bytes_free,
  output logic [blaf_pkg::DROP_W-1:0]    drop_total
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = blaf_pkg::BYTE_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_AGE  = 1'b1;

  logic state;
  logic [BW-1:0] max_bytes;
  logic [blaf_pkg::TIME_W-1:0] max_delay;

  logic [AW-1:0] head, head_next, tail, tail_next, head_inc, tail_inc;
  logic [CW-1:0] count, count_next, expired, expired_next;
  logic [BW-1:0] byte_total, byte_total_next;
  logic [blaf_pkg::DROP_W-1:0] refused, refused_next;

  logic [1:0] op_q;
  logic [blaf_pkg::TIME_W-1:0] now_q;
  logic [blaf_pkg::HND_W-1:0] hnd_q;
  logic [blaf_pkg::LEN_W-1:0] len_q;

  blaf_pkg::desc_t rd_data, wr_data;
  logic wr_en;

  logic accept, is_old, finish;
  logic [blaf_pkg::TIME_W-1:0] age;
  logic [BW:0] sum;
  logic [blaf_pkg::STAT_W-1:0] stat_v;
  logic [blaf_pkg::HND_W-1:0] oh_v;
  logic [blaf_pkg::LEN_W-1:0] ol_v;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
  assign age      = now_q - rd_data.stamp;
  assign is_old   = (state == S_AGE) && (count != '0) && (age >= max_delay);
  assign sum      = {1'b0, byte_total} + (BW + 1)'(len_q);

  assign wr_data.handle = hnd_q;
  assign wr_data.length = len_q;
  assign wr_data.stamp  = now_q;

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    byte_total_next = byte_total;
    refused_next    = refused;
    expired_next    = expired;
    wr_en           = 1'b0;
    finish          = 1'b0;
    stat_v          = blaf_pkg::ST_QUERIED;
    oh_v            = '0;
    ol_v            = '0;
    if (accept) begin
      expired_next = '0;
      if (operation == blaf_pkg::OP_FLUSH) begin
        head_next       = '0;
        tail_next       = '0;
        count_next      = '0;
        byte_total_next = '0;
        stat_v          = blaf_pkg::ST_FLUSHED;
        finish          = 1'b1;
      end
    end else if (is_old) begin
      head_next       = head_inc;
      count_next      = count - 1'b1;
      byte_total_next = byte_total - BW'(rd_data.length);
      expired_next    = expired + 1'b1;
    end else if (state == S_AGE) begin
      finish = 1'b1;
      case (op_q)
        blaf_pkg::OP_ENQUEUE: begin
          if (sum >= {1'b0, max_bytes}) begin
            refused_next = refused + 1'b1;
            stat_v       = blaf_pkg::ST_DROP_BYTES;
          end else if (count == CW'(DEPTH)) begin
            refused_next = refused + 1'b1;
            stat_v       = blaf_pkg::ST_DROP_FULL;
          end else begin
            wr_en           = 1'b1;
            tail_next       = tail_inc;
            count_next      = count + 1'b1;
            byte_total_next = sum[BW-1:0];
            stat_v          = blaf_pkg::ST_ACCEPTED;
          end
        end
        blaf_pkg::OP_DEQUEUE: begin
          if (count == '0) begin
            stat_v = blaf_pkg::ST_EMPTY;
          end else begin
            oh_v            = rd_data.handle;
            ol_v            = rd_data.length;
            head_next       = head_inc;
            count_next      = count - 1'b1;
            byte_total_next = byte_total - BW'(rd_data.length);
            stat_v          = blaf_pkg::ST_DEQUEUED;
          end
        end
        blaf_pkg::OP_QUERY: begin
          stat_v = blaf_pkg::ST_QUERIED;
        end
        default: begin
          stat_v = blaf_pkg::ST_FLUSHED;
        end
      endcase
    end
  end

  blaf_desc_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_addr (head_next),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      max_bytes  <= blaf_pkg::MAX_BYTES_RESET;
      max_delay  <= blaf_pkg::MAX_DELAY_RESET;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      byte_total <= '0;
      refused    <= '0;
      expired    <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == blaf_pkg::REG_MAX_BYTES) begin
          max_bytes <= cfg_data[BW-1:0];
        end else begin
          max_delay <= cfg_data[blaf_pkg::TIME_W-1:0];
        end
      end
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      byte_total <= byte_total_next;
      refused    <= refused_next;
      expired    <= expired_next;
      done       <= finish;
      if (accept && operation != blaf_pkg::OP_FLUSH) begin
        state <= S_AGE;
      end else if (finish) begin
        state <= S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      now_q <= current_time;
      hnd_q <= packet_handle;
      len_q <= packet_length;
    end
    if (finish) begin
      status        <= stat_v;
      out_handle    <= oh_v;
      out_length    <= ol_v;
      expired_count <= blaf_pkg::CNT_W'(expired_next);
      packet_count  <= blaf_pkg::CNT_W'(count_next);
      bytes_held    <= byte_total_next;
      bytes_free    <= (max_bytes > byte_total_next) ? max_bytes - byte_total_next : '0;
      drop_total    <= refused_next;
    end
  end

endmodule

[sim/byte_limited_aging_fifo_check.sv]
`timescale 1ns / 1ps

module byte_limited_aging_fifo_check
  import blaf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          operation,
  input  logic [TIME_W-1:0]   current_time,
  input  logic [HND_W-1:0]    packet_handle,
  input  logic [LEN_W-1:0]    packet_length,
  input  logic                done,
  input  logic [STAT_W-1:0]   status,
  input  logic [HND_W-1:0]    out_handle,
  input  logic [LEN_W-1:0]    out_length,
  input  logic [CNT_W-1:0]    expired_count,
  input  logic [CNT_W-1:0]    packet_count,
  input  logic [BYTE_W-1:0]   bytes_held,
  input  logic [BYTE_W-1:0]   bytes_free,
  input  logic [DROP_W-1:0]   drop_total,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_checked,
  output int                  aged_total,
  output int                  refused_seen
);

  localparam int SLOTS = DEPTH_DEFAULT;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HND_W-1:0]  handle;
    logic [LEN_W-1:0]  length;
    logic [CNT_W-1:0]  expired;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] held;
    logic [BYTE_W-1:0] free;
    logic [DROP_W-1:0] drops;
  } outcome_t;

  logic [HND_W-1:0]  handle_mem [SLOTS];
  logic [LEN_W-1:0]  length_mem [SLOTS];
  logic [TIME_W-1:0] stamp_mem  [SLOTS];
  int                head_slot;
  int                tail_slot;
  int                held_count;
  logic [BYTE_W-1:0] held_bytes;
  logic [BYTE_W-1:0] byte_limit;
  logic [TIME_W-1:0] age_limit;
  logic [DROP_W-1:0] refusals;
  outcome_t          awaited [$];

  function automatic void pop_oldest();
    held_bytes = held_bytes - length_mem[head_slot];
    head_slot  = (head_slot == SLOTS-1) ? 0 : head_slot + 1;
    held_count--;
  endfunction

  function automatic outcome_t fifo_step(logic [1:0] op, logic [TIME_W-1:0] now,
                                         logic [HND_W-1:0] hnd, logic [LEN_W-1:0] len);
    outcome_t       r;
    logic [BYTE_W:0] total;
    r = '0;
    if (op == OP_FLUSH) begin
      head_slot  = 0;
      tail_slot  = 0;
      held_count = 0;
      held_bytes = '0;
      r.status   = ST_FLUSHED;
    end else begin
      // expiry is only ever tested at the head
      while (held_count != 0 && (now - stamp_mem[head_slot]) >= age_limit) begin
        pop_oldest();
        r.expired = r.expired + 1'b1;
      end
      case (op)
        OP_ENQUEUE: begin
          total = {1'b0, held_bytes} + len;
          if (total >= byte_limit) begin
            refusals = refusals + 1'b1;
            r.status = ST_DROP_BYTES;
          end else if (held_count >= SLOTS) begin
            refusals = refusals + 1'b1;
            r.status = ST_DROP_FULL;
          end else begin
            handle_mem[tail_slot] = hnd;
            length_mem[tail_slot] = len;
            stamp_mem[tail_slot]  = now;
            tail_slot  = (tail_slot == SLOTS-1) ? 0 : tail_slot + 1;
            held_count++;
            held_bytes = total[BYTE_W-1:0];
            r.status   = ST_ACCEPTED;
          end
        end
        OP_DEQUEUE: begin
          if (held_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.handle = handle_mem[head_slot];
            r.length = length_mem[head_slot];
            pop_oldest();
            r.status = ST_DEQUEUED;
          end
        end
        default: r.status = ST_QUERIED;
      endcase
    end
    r.count = CNT_W'(held_count);
    r.held  = held_bytes;
    r.free  = (byte_limit > held_bytes) ? byte_limit - held_bytes : '0;
    r.drops = refusals;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    aged_total      = 0;
    refused_seen    = 0;
  end

  always @(posedge clk) begin
    outcome_t want;
    outcome_t fresh;
    if (rst) begin
      head_slot  = 0;
      tail_slot  = 0;
      held_count = 0;
      held_bytes = '0;
      refusals   = '0;
      byte_limit = MAX_BYTES_RESET;
      age_limit  = MAX_DELAY_RESET;
      awaited.delete();
    end else begin
      if (cfg_write === 1'b1) begin
        if (cfg_index == REG_MAX_BYTES) byte_limit = cfg_data[BYTE_W-1:0];
        else age_limit = cfg_data[TIME_W-1:0];
      end
      if (done === 1'b1) begin
        if (awaited.size() == 0) begin
          $error("result with status %0d arrived with no request pending", status);
          mismatches++;
        end else begin
          want = awaited[0];
          awaited.delete(0);
          check_field("status", want.status, status);
          check_field("out_handle", want.handle, out_handle);
          check_field("out_length", want.length, out_length);
          check_field("expired_count", want.expired, expired_count);
          check_field("packet_count", want.count, packet_count);
          check_field("bytes_held", want.held, bytes_held);
          check_field("bytes_free", want.free, bytes_free);
          check_field("drop_total", want.drops, drop_total);
          results_checked++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        fresh = fifo_step(operation, current_time, packet_handle, packet_length);
        aged_total += fresh.expired;
        if (fresh.status == ST_DROP_BYTES || fresh.status == ST_DROP_FULL) refused_seen++;
        awaited.insert(awaited.size(), fresh);
      end
    end
    outstanding = awaited.size();
  end

endmodule

[sim/byte_limited_aging_fifo_test.sv]
`timescale 1ns / 1ps

module byte_limited_aging_fifo_test;
  import blaf_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic                cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                start;
  logic                busy;
  logic [1:0]          operation;
  logic [TIME_W-1:0]   current_time;
  logic [HND_W-1:0]    packet_handle;
  logic [LEN_W-1:0]    packet_length;
  logic                done;
  logic [STAT_W-1:0]   status;
  logic [HND_W-1:0]    out_handle;
  logic [LEN_W-1:0]    out_length;
  logic [CNT_W-1:0]    expired_count;
  logic [CNT_W-1:0]    packet_count;
  logic [BYTE_W-1:0]   bytes_held;
  logic [BYTE_W-1:0]   bytes_free;
  logic [DROP_W-1:0]   drop_total;
  int                  mismatches;
  int                  outstanding;
  int                  results_checked;
  int                  aged_total;
  int                  refused_seen;
  logic [TIME_W-1:0]   tick_now;

  byte_limited_aging_fifo u_top (.*);
  byte_limited_aging_fifo_check u_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[byte_limited_aging_fifo] ERROR");
    $finish;
  end

  task automatic issue_request(input logic [1:0] op, input logic [TIME_W-1:0] t,
                               input logic [HND_W-1:0] h, input logic [LEN_W-1:0] l);
    @(negedge clk);
    start         <= 1'b1;
    operation     <= op;
    current_time  <= t;
    packet_handle <= h;
    packet_length <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain_pending();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_traffic(input int count, input int idle_pct, input int len_cap,
                             input int step);
    int          pick;
    logic [1:0]  op;
    logic [LEN_W-1:0] len;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50)      op = OP_ENQUEUE;
      else if (pick < 80) op = OP_DEQUEUE;
      else if (pick < 96) op = OP_QUERY;
      else                op = OP_FLUSH;
      pick = $urandom_range(99);
      if (pick < 2)      tick_now = $urandom();
      else if (pick < 5) tick_now -= TIME_W'($urandom_range(step * 4));
      else               tick_now += TIME_W'($urandom_range(step));
      len = ($urandom_range(15) == 0) ? LEN_W'($urandom()) : LEN_W'($urandom_range(len_cap));
      if ($urandom_range(99) < idle_pct) begin
        @(negedge clk);
        start <= 1'b0;
        while ($urandom_range(99) < idle_pct) @(negedge clk);
      end
      issue_request(op, tick_now, HND_W'($urandom()), len);
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_MAX_BYTES;
    cfg_data      = '0;
    start         = 1'b0;
    operation     = OP_QUERY;
    current_time  = '0;
    packet_handle = '0;
    packet_length = '0;
    tick_now      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default limits: empty, field extremes, byte limit edge
    issue_request(OP_QUERY, 32'd0, 16'h0000, 16'h0000);
    issue_request(OP_DEQUEUE, 32'd0, 16'hFFFF, 16'hFFFF);
    issue_request(OP_ENQUEUE, 32'd0, 16'hFFFF, 16'hFFFF);
    issue_request(OP_ENQUEUE, 32'd1, 16'h0000, 16'hFFFF);
    issue_request(OP_ENQUEUE, 32'd5, 16'h1234, 16'd0);
    issue_request(OP_ENQUEUE, 32'd6, 16'h5555, 16'd34465);
    issue_request(OP_ENQUEUE, 32'd7, 16'hAAAA, 16'd34464);
    issue_request(OP_QUERY, 32'd8, 16'h0000, 16'h0000);
    issue_request(OP_DEQUEUE, 32'd9, 16'h0000, 16'h0000);
    issue_request(OP_FLUSH, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
    issue_request(OP_QUERY, 32'd11, 16'h0000, 16'h0000);

    // zero delay ages out everything at the next request
    drain_pending();
    write_reg(REG_MAX_DELAY, 32'd0);
    issue_request(OP_ENQUEUE, 32'd100, 16'h0001, 16'd10);
    issue_request(OP_ENQUEUE, 32'd100, 16'h0002, 16'd20);
    issue_request(OP_QUERY, 32'd100, 16'h0000, 16'h0000);

    // aging stops at a live head even when a later stamp looks old
    drain_pending();
    write_reg(REG_MAX_DELAY, 32'd100);
    issue_request(OP_ENQUEUE, 32'd1000, 16'h00A0, 16'd1);
    issue_request(OP_ENQUEUE, 32'd1050, 16'h00B0, 16'd2);
    issue_request(OP_QUERY, 32'd1020, 16'h0000, 16'h0000);
    issue_request(OP_QUERY, 32'd1100, 16'h0000, 16'h0000);
    issue_request(OP_ENQUEUE, 32'hFFFF_FFF0, 16'h00C0, 16'd3);
    issue_request(OP_QUERY, 32'h0000_0050, 16'h0000, 16'h0000);
    issue_request(OP_DEQUEUE, 32'h0000_005F, 16'h0000, 16'h0000);

    drain_pending();
    write_reg(REG_MAX_BYTES, {12'($urandom()), 20'hFFFFF});
    write_reg(REG_MAX_DELAY, 32'hFFFF_FFFF);
    tick_now = 32'd2000;
    run_traffic(300, 0, 4000, 8);

    drain_pending();
    write_reg(REG_MAX_BYTES, {12'($urandom()), 20'd5000});
    write_reg(REG_MAX_DELAY, 32'd300);
    tick_now = 32'hFFFF_F000;
    run_traffic(300, 67, 1500, 20);

    // fill the store, then hit both limits at once
    drain_pending();
    write_reg(REG_MAX_BYTES, {12'($urandom()), 20'd600});
    write_reg(REG_MAX_DELAY, 32'hFFFF_FFFF);
    issue_request(OP_FLUSH, tick_now, 16'h0000, 16'h0000);
    for (int i = 0; i < DEPTH_DEFAULT + 3; i++) begin
      tick_now += 1;
      issue_request(OP_ENQUEUE, tick_now, HND_W'($urandom()), 16'd1);
    end
    issue_request(OP_ENQUEUE, tick_now, HND_W'($urandom()), 16'd100);
    drain_pending();
    write_reg(REG_MAX_BYTES, 32'd100);
    issue_request(OP_QUERY, tick_now, 16'h0000, 16'h0000);
    repeat (3) issue_request(OP_DEQUEUE, tick_now, 16'h0000, 16'h0000);
    drain_pending();
    write_reg(REG_MAX_DELAY, 32'd1000);
    tick_now += 5000;
    issue_request(OP_QUERY, tick_now, 16'h0000, 16'h0000);
    issue_request(OP_ENQUEUE, tick_now, HND_W'($urandom()), 16'd0);
    drain_pending();
    write_reg(REG_MAX_BYTES, 32'd0);
    issue_request(OP_ENQUEUE, tick_now, HND_W'($urandom()), 16'd0);

    drain_pending();
    write_reg(REG_MAX_DELAY, 32'd0);
    run_traffic(100, 32, 100, 5);

    drain_pending();
    write_reg(REG_MAX_BYTES, {12'($urandom()), 20'($urandom_range(200000, 2000))});
    write_reg(REG_MAX_DELAY, 32'($urandom_range(5000, 50)));
    run_traffic(250, 32, 3000, 20);

    drain_pending();
    write_reg(REG_MAX_BYTES, 32'd20000);
    write_reg(REG_MAX_DELAY, 32'd800);
    run_traffic(250, 0, 600, 10);

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Checked %0d requests across many byte and delay limits, a full store,",
             results_checked);
    $display("gapped and gapless traffic; aged out: %0d, enqueues refused: %0d.",
             aged_total, refused_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[byte_limited_aging_fifo] OK");
    end else begin
      $display("[byte_limited_aging_fifo] ERROR");
    end
    $finish;
  end

endmodule
